// ----- src/deq_pkg.sv -----
// shared types, constants and helpers for the double-ended queue
// depends on nothing; used by the interfaces, the cell, the chain and the top level

package deq_pkg;

   localparam int DEPTH = 16;
   localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   localparam int REQ_TYPE_W    = 2;
   localparam int VALUE_W       = 32;
   localparam int STATUS_W      = 2;
   localparam int ENTRY_COUNT_W = 5;

   typedef logic signed [VALUE_W-1:0] value_type;
   typedef logic [CNT_W-1:0]          count_type;
   typedef logic [IDX_W-1:0]          index_type;

   typedef enum logic [REQ_TYPE_W-1:0] {
      REQ_PUSH_FRONT = 2'd0,
      REQ_PUSH_BACK  = 2'd1,
      REQ_POP_FRONT  = 2'd2,
      REQ_POP_BACK   = 2'd3
   } req_code_type;

   typedef enum logic [STATUS_W-1:0] {
      STATUS_DONE  = 2'd0,
      STATUS_EMPTY = 2'd1,
      STATUS_FULL  = 2'd2
   } status_type;

   // per-cell controls, driven by the chain each cycle
   typedef struct packed {
      logic load;         // take the pushed value (push at back)
      logic shift_right;  // take left neighbor (push at front)
      logic shift_left;   // take right neighbor (pop at front)
   } cell_ctl_type;

   typedef struct packed {
      status_type                 status;
      value_type                  pop_value;
      logic [ENTRY_COUNT_W-1:0]   entry_count;
   } rsp_fields_type;

   // count masked to the width of the result field
   function automatic logic [ENTRY_COUNT_W-1:0] count_field(input count_type cnt);
      logic [CNT_W+ENTRY_COUNT_W-1:0] wide;
      wide = {{ENTRY_COUNT_W{1'b0}}, cnt};
      return wide[ENTRY_COUNT_W-1:0];
   endfunction

endpackage

// ----- src/deq_req_if.sv -----
// request channel: valid/ready handshake carrying one queue operation
// depends on deq_pkg

interface deq_req_if;
   logic                              valid;
   logic                              ready;
   logic [deq_pkg::REQ_TYPE_W-1:0]    req_type;
   logic signed [deq_pkg::VALUE_W-1:0] push_value;

   modport source (output valid, output req_type, output push_value, input ready);
   modport sink   (input valid, input req_type, input push_value, output ready);
endinterface

// ----- src/deq_rsp_if.sv -----
// response channel: valid/ready handshake carrying one operation result
// depends on deq_pkg

interface deq_rsp_if;
   logic                                 valid;
   logic                                 ready;
   logic [deq_pkg::STATUS_W-1:0]         status;
   logic signed [deq_pkg::VALUE_W-1:0]   pop_value;
   logic [deq_pkg::ENTRY_COUNT_W-1:0]    entry_count;

   modport source (output valid, output status, output pop_value, output entry_count,
                   input ready);
   modport sink   (input valid, input status, input pop_value, input entry_count,
                   output ready);
endinterface

// ----- src/deq_cell.sv -----
// one storage cell of the chain: holds one entry, loads push value or a neighbor
// depends on deq_pkg

module deq_cell (
   input  logic                   clock,
   input  deq_pkg::cell_ctl_type  ctl,
   input  deq_pkg::value_type     from_left,
   input  deq_pkg::value_type     from_right,
   input  deq_pkg::value_type     push_value,
   output deq_pkg::value_type     data_q
);

   deq_pkg::value_type data_ff;
   deq_pkg::value_type data_in;

   always_comb begin
      data_in = data_ff;
      priority if (ctl.load) begin
         data_in = push_value;
      end else if (ctl.shift_right) begin
         data_in = from_left;
      end else if (ctl.shift_left) begin
         data_in = from_right;
      end else begin
         data_in = data_ff;
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   assign data_q = data_ff;

endmodule

// ----- src/deq_chain.sv -----
// row of deq_cell entries with the fill count; front entry sits in cell 0
// depends on deq_pkg and deq_cell

module deq_chain (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     op_valid,
   input  deq_pkg::req_code_type    req_code,
   input  deq_pkg::value_type       push_value,
   output deq_pkg::rsp_fields_type  result
);

   deq_pkg::count_type   count_ff;
   deq_pkg::count_type   count_in;
   deq_pkg::count_type   count_dec;
   deq_pkg::index_type   back_idx;
   deq_pkg::value_type   cell_q [deq_pkg::DEPTH];
   deq_pkg::cell_ctl_type cell_ctl [deq_pkg::DEPTH];
   deq_pkg::status_type  status;
   deq_pkg::value_type   pop_value;
   logic                 full;
   logic                 empty;
   logic                 push_front_go;
   logic                 push_back_go;
   logic                 pop_front_go;

   assign full      = (count_ff == deq_pkg::CNT_W'(deq_pkg::DEPTH));
   assign empty     = (count_ff == '0);
   assign count_dec = count_ff - deq_pkg::CNT_W'(1);
   assign back_idx  = count_dec[deq_pkg::IDX_W-1:0];

   always_comb begin
      status    = deq_pkg::STATUS_DONE;
      pop_value = '0;
      count_in  = count_ff;
      unique case (req_code)
         deq_pkg::REQ_PUSH_FRONT, deq_pkg::REQ_PUSH_BACK: begin
            if (full) begin
               status = deq_pkg::STATUS_FULL;
            end else begin
               count_in = count_ff + deq_pkg::CNT_W'(1);
            end
         end
         deq_pkg::REQ_POP_FRONT: begin
            if (empty) begin
               status = deq_pkg::STATUS_EMPTY;
            end else begin
               pop_value = cell_q[0];
               count_in  = count_dec;
            end
         end
         deq_pkg::REQ_POP_BACK: begin
            if (empty) begin
               status = deq_pkg::STATUS_EMPTY;
            end else begin
               pop_value = cell_q[back_idx];
               count_in  = count_dec;
            end
         end
         default: begin
            status = deq_pkg::STATUS_DONE;
         end
      endcase
   end

   assign push_front_go = op_valid && !full && (req_code == deq_pkg::REQ_PUSH_FRONT);
   assign push_back_go  = op_valid && !full && (req_code == deq_pkg::REQ_PUSH_BACK);
   assign pop_front_go  = op_valid && !empty && (req_code == deq_pkg::REQ_POP_FRONT);

   for (genvar i = 0; i < deq_pkg::DEPTH; i++) begin : g_cell
      deq_pkg::value_type left_data;
      deq_pkg::value_type right_data;

      if (i == 0) begin : g_first
         assign left_data = push_value;
      end else begin : g_inner_l
         assign left_data = cell_q[i-1];
      end

      if (i == deq_pkg::DEPTH - 1) begin : g_last
         assign right_data = '0;
      end else begin : g_inner_r
         assign right_data = cell_q[i+1];
      end

      // back push lands at the first free cell, which is the count itself
      assign cell_ctl[i].load = push_back_go &&
         (count_ff[deq_pkg::IDX_W-1:0] == deq_pkg::IDX_W'(i));
      assign cell_ctl[i].shift_right = push_front_go;
      assign cell_ctl[i].shift_left  = pop_front_go;

      deq_cell u_cell (
         .clock      (clock),
         .ctl        (cell_ctl[i]),
         .from_left  (left_data),
         .from_right (right_data),
         .push_value (push_value),
         .data_q     (cell_q[i])
      );
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else if (op_valid) begin
         count_ff <= count_in;
      end
   end

   assign result.status      = status;
   assign result.pop_value   = pop_value;
   assign result.entry_count = deq_pkg::count_field(count_in);

`ifndef SYNTHESIS
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= deq_pkg::CNT_W'(deq_pkg::DEPTH))
      else $error("fill count above depth");

   a_push_grows: assert property (@(posedge clock) disable iff (reset)
      (op_valid && !full && (req_code == deq_pkg::REQ_PUSH_FRONT ||
                             req_code == deq_pkg::REQ_PUSH_BACK))
      |=> (count_ff == $past(count_ff) + deq_pkg::CNT_W'(1)))
      else $error("accepted push did not grow the queue");

   a_refused_holds: assert property (@(posedge clock) disable iff (reset)
      (op_valid && status != deq_pkg::STATUS_DONE) |=> $stable(count_ff))
      else $error("refused transaction changed the fill count");

   a_front_lifo: assert property (@(posedge clock) disable iff (reset)
      (op_valid && !full && req_code == deq_pkg::REQ_PUSH_FRONT) ##1
      (op_valid && req_code == deq_pkg::REQ_POP_FRONT)
      |-> (result.pop_value == $past(push_value)))
      else $error("pop front did not return the value just pushed at front");
`endif

endmodule

// ----- src/double_ended_queue_top.sv -----
// top level of the double-ended queue: request/response handshake and result register
// depends on deq_pkg, deq_req_if, deq_rsp_if and deq_chain

// Bounded double-ended queue of DEPTH (16) signed 32-bit entries. Each request
// transaction pushes at the front, pushes at the back, pops the front or pops the
// back, and yields exactly one response transaction with a status (done, empty on
// a pop, full on a push), the popped value (zero unless a pop succeeded) and the
// number of entries held afterwards. Entries live in a chain of cells with the
// front always in the first cell: a front push shifts the whole chain one cell
// back, a front pop shifts it one cell forward, a back push loads the cell at
// the fill count and a back pop reads the cell just below it. The block takes one
// request per cycle, limited only by how fast the response side takes results;
// the response appears in the result register in the cycle after the request is
// taken, and a new request is taken whenever that register is empty or being
// drained in the same cycle. No clearing pass is needed after reset; entry
// contents are only read once pushed.

module double_ended_queue_top (
   input  logic       clock,
   input  logic       reset,
   deq_req_if.sink    req_chan,
   deq_rsp_if.source  rsp_chan
);

   logic                    req_accept;
   deq_pkg::rsp_fields_type chain_result;

   // result register
   logic                    rsp_valid_ff;
   logic                    rsp_valid_in;
   deq_pkg::rsp_fields_type rsp_data_ff;

   // take a new transaction when the result slot is free or draining now
   assign req_chan.ready = !reset && (!rsp_valid_ff || rsp_chan.ready);
   assign req_accept     = req_chan.valid && req_chan.ready;

   deq_chain u_chain (
      .clock      (clock),
      .reset      (reset),
      .op_valid   (req_accept),
      .req_code   (deq_pkg::req_code_type'(req_chan.req_type)),
      .push_value (req_chan.push_value),
      .result     (chain_result)
   );

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      priority if (req_accept) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload needs no reset, it is qualified by the valid flag
   always_ff @(posedge clock) begin
      if (req_accept) begin
         rsp_data_ff <= chain_result;
      end
   end

   assign rsp_chan.valid       = rsp_valid_ff;
   assign rsp_chan.status      = rsp_data_ff.status;
   assign rsp_chan.pop_value   = rsp_data_ff.pop_value;
   assign rsp_chan.entry_count = rsp_data_ff.entry_count;

endmodule
